// ===== design/rtbd_pkg.sv =====
`timescale 1ns / 1ps

package rtbd_pkg;

  localparam int CELL_STRIDE  = 4;
  localparam int CORDIC_STEPS = 16;

  localparam int ZW = 20;
  localparam int XW = 19;
  localparam int DW = 17;
  localparam int PW = 33;
  localparam int MW = 36;

  localparam logic signed [XW-1:0] CORDIC_GAIN_Q16 = 19'sd39797;
  localparam logic signed [ZW-1:0] PI_Q16          = 20'sd205887;
  localparam logic signed [ZW-1:0] HALF_PI_Q16     = 20'sd102944;
  localparam logic signed [PW-1:0] DEG_PER_RAD     = 33'sd58671;
  localparam logic signed [PW-1:0] DEG_HALF        = 33'sd32768;
  localparam int DEG_LIMIT   = 23040;
  localparam int CENTER_MAX  = 524287;
  localparam int CENTER_MIN  = -524288;
  localparam int CENTER_HALF = 65536;
  localparam int FRAC_SHIFT  = 17;

  localparam logic signed [ZW-1:0] ATAN_Q16 [CORDIC_STEPS] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2
  };

  typedef struct packed {
    logic signed [ZW-1:0] z;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic                 flip;
  } rtbd_rot_t;

  typedef struct packed {
    logic        [7:0]    col;
    logic        [7:0]    row;
    logic        [15:0]   score;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    logic        [DW-1:0] width;
    logic        [DW-1:0] height;
    logic signed [PW-1:0] deg_prod;
  } rtbd_side_t;

  typedef struct packed {
    logic        [15:0] confidence;
    logic signed [15:0] angle_deg;
    logic        [16:0] box_height;
    logic        [16:0] box_width;
    logic signed [19:0] center_y;
    logic signed [19:0] center_x;
  } rtbd_box_t;

endpackage

// ===== design/rtbd_cordic.sv =====
`timescale 1ns / 1ps

module rtbd_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rtbd_pkg::rtbd_rot_t  rot_i,
  input  rtbd_pkg::rtbd_side_t side_i,
  output logic               valid_o,
  output rtbd_pkg::rtbd_rot_t  rot_o,
  output rtbd_pkg::rtbd_side_t side_o
);

  localparam int Steps = rtbd_pkg::CORDIC_STEPS;

  logic                 valid_q [Steps];
  rtbd_pkg::rtbd_rot_t  rot_q   [Steps];
  rtbd_pkg::rtbd_side_t side_q  [Steps];

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic                 prev_valid;
    rtbd_pkg::rtbd_rot_t  prev_rot;
    rtbd_pkg::rtbd_rot_t  rot_d;
    rtbd_pkg::rtbd_side_t prev_side;

    if (i == 0) begin : g_first
      assign prev_valid = valid_i;
      assign prev_rot   = rot_i;
      assign prev_side  = side_i;
    end else begin : g_next
      assign prev_valid = valid_q[i-1];
      assign prev_rot   = rot_q[i-1];
      assign prev_side  = side_q[i-1];
    end

    always_comb begin
      rot_d = prev_rot;
      if (!prev_rot.z[rtbd_pkg::ZW-1]) begin
        rot_d.x = prev_rot.x - (prev_rot.y >>> i);
        rot_d.y = prev_rot.y + (prev_rot.x >>> i);
        rot_d.z = prev_rot.z - rtbd_pkg::ATAN_Q16[i];
      end else begin
        rot_d.x = prev_rot.x + (prev_rot.y >>> i);
        rot_d.y = prev_rot.y - (prev_rot.x >>> i);
        rot_d.z = prev_rot.z + rtbd_pkg::ATAN_Q16[i];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= prev_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rot_q[i]  <= rot_d;
        side_q[i] <= prev_side;
      end
    end
  end

  assign valid_o = valid_q[Steps-1];
  assign rot_o   = rot_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ===== design/rtbd_center.sv =====
`timescale 1ns / 1ps

module rtbd_center #(
  parameter int CellStride = rtbd_pkg::CELL_STRIDE
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  rtbd_pkg::rtbd_rot_t  rot_i,
  input  rtbd_pkg::rtbd_side_t side_i,
  output logic                 valid_o,
  output rtbd_pkg::rtbd_box_t  box_o
);

  localparam int StrideQ4 = CellStride * 16;
  localparam int BaseW    = $clog2(256 * StrideQ4) + rtbd_pkg::FRAC_SHIFT + 1;
  localparam int MW       = rtbd_pkg::MW;
  localparam int SumW     = ((BaseW > MW) ? BaseW : MW) + 2;
  localparam int PW       = rtbd_pkg::PW;

  logic signed [rtbd_pkg::XW-1:0] cos_v, sin_v;
  logic signed [MW-1:0]   p_cdx_d, p_sdy_d, p_cdy_d, p_sdx_d;
  logic signed [MW-1:0]   p_cdx_q, p_sdy_q, p_cdy_q, p_sdx_q;
  logic signed [SumW-1:0] base_x_d, base_y_d, base_x_q, base_y_q;
  logic [15:0]            conf_q;
  logic [16:0]            width_q, height_q;
  logic signed [PW-1:0]   deg_prod_q;
  logic                   valid_m_q;

  logic signed [SumW-1:0] sum_x, sum_y, sh_x, sh_y;
  logic signed [PW-1:0]   deg_r;
  rtbd_pkg::rtbd_box_t    box_d, box_q;
  logic                   valid_q;

  // sign fix after the pi reduction, then the four rotation products
  always_comb begin
    cos_v    = rot_i.flip ? -rot_i.x : rot_i.x;
    sin_v    = rot_i.flip ? -rot_i.y : rot_i.y;
    p_cdx_d  = MW'(cos_v) * MW'(side_i.dx);
    p_sdy_d  = MW'(sin_v) * MW'(side_i.dy);
    p_cdy_d  = MW'(cos_v) * MW'(side_i.dy);
    p_sdx_d  = MW'(sin_v) * MW'(side_i.dx);
    base_x_d = $signed(SumW'(side_i.col) * SumW'(StrideQ4)) <<< rtbd_pkg::FRAC_SHIFT;
    base_y_d = $signed(SumW'(side_i.row) * SumW'(StrideQ4)) <<< rtbd_pkg::FRAC_SHIFT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_m_q <= 1'b0;
      valid_q   <= 1'b0;
    end else if (en_i) begin
      valid_m_q <= valid_i;
      valid_q   <= valid_m_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_cdx_q    <= p_cdx_d;
      p_sdy_q    <= p_sdy_d;
      p_cdy_q    <= p_cdy_d;
      p_sdx_q    <= p_sdx_d;
      base_x_q   <= base_x_d;
      base_y_q   <= base_y_d;
      conf_q     <= side_i.score;
      width_q    <= side_i.width;
      height_q   <= side_i.height;
      deg_prod_q <= side_i.deg_prod;
      box_q      <= box_d;
    end
  end

  // round half up, then saturate
  always_comb begin
    sum_x = base_x_q + SumW'(p_cdx_q) + SumW'(p_sdy_q) + SumW'(rtbd_pkg::CENTER_HALF);
    sum_y = base_y_q + SumW'(p_cdy_q) - SumW'(p_sdx_q) + SumW'(rtbd_pkg::CENTER_HALF);
    sh_x  = sum_x >>> rtbd_pkg::FRAC_SHIFT;
    sh_y  = sum_y >>> rtbd_pkg::FRAC_SHIFT;
    deg_r = (deg_prod_q + rtbd_pkg::DEG_HALF) >>> 16;

    box_d            = '0;
    box_d.confidence = conf_q;
    box_d.box_width  = width_q;
    box_d.box_height = height_q;

    if (sh_x > SumW'(rtbd_pkg::CENTER_MAX)) begin
      box_d.center_x = 20'(rtbd_pkg::CENTER_MAX);
    end else if (sh_x < SumW'(rtbd_pkg::CENTER_MIN)) begin
      box_d.center_x = 20'(rtbd_pkg::CENTER_MIN);
    end else begin
      box_d.center_x = sh_x[19:0];
    end

    if (sh_y > SumW'(rtbd_pkg::CENTER_MAX)) begin
      box_d.center_y = 20'(rtbd_pkg::CENTER_MAX);
    end else if (sh_y < SumW'(rtbd_pkg::CENTER_MIN)) begin
      box_d.center_y = 20'(rtbd_pkg::CENTER_MIN);
    end else begin
      box_d.center_y = sh_y[19:0];
    end

    if (deg_r > PW'(rtbd_pkg::DEG_LIMIT)) begin
      box_d.angle_deg = 16'(rtbd_pkg::DEG_LIMIT);
    end else if (deg_r < -PW'(rtbd_pkg::DEG_LIMIT)) begin
      box_d.angle_deg = -16'(rtbd_pkg::DEG_LIMIT);
    end else begin
      box_d.angle_deg = deg_r[15:0];
    end
  end

  assign valid_o = valid_q;
  assign box_o   = box_q;

endmodule

// ===== design/rotated_text_box_decoder.sv =====
`timescale 1ns / 1ps
// channel   | dir | handshake              | payload
// ----------+-----+------------------------+----------------------------------------------
// s_axis    | in  | s_axis_tvalid / tready | one map cell, 112-bit tdata
// m_axis    | out | m_axis_tvalid / tready | one rotated box, 112-bit tdata
// cfg       | in  | cfg_we_i               | score_threshold, 16 bit
//
// one cell per cycle sustained while the output is not stalled; each box passes through the
// input stage, setup stage, 16 cordic stages, multiply stage and output stage
// cells below the threshold leave a bubble and produce no transfer
// the whole pipeline advances whenever the output register is empty or taken
// reset clears valid bits only and sets the threshold to 16384

module rotated_text_box_decoder #(
  parameter int CellStride = rtbd_pkg::CELL_STRIDE
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cell_col, cell_row, score, dist_top, dist_right, dist_bottom, dist_left, angle_rad
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // center_x, center_y, box_width, box_height, angle_deg, confidence, zero pad
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [15:0]  cfg_wdata_i
);

  localparam int ZW = rtbd_pkg::ZW;
  localparam int DW = rtbd_pkg::DW;
  localparam int PW = rtbd_pkg::PW;

  logic        en;
  logic [15:0] thr_q;

  logic        valid_in_q;
  logic [7:0]  col_q, row_q;
  logic [15:0] score_q, top_q, right_q, bottom_q, left_q;
  logic signed [15:0] ang_q;

  logic signed [ZW-1:0]  z_raw;
  rtbd_pkg::rtbd_rot_t   rot_d, rot_q;
  rtbd_pkg::rtbd_side_t  side_d, side_q;
  logic                  valid_set_q;

  logic                  cor_valid;
  rtbd_pkg::rtbd_rot_t   cor_rot;
  rtbd_pkg::rtbd_side_t  cor_side;
  logic                  out_valid;
  rtbd_pkg::rtbd_box_t   box;

  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= 16'd16384;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_in_q  <= 1'b0;
      valid_set_q <= 1'b0;
    end else if (en) begin
      valid_in_q  <= s_axis_tvalid && (s_axis_tdata[31:16] >= thr_q);
      valid_set_q <= valid_in_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_q    <= s_axis_tdata[7:0];
      row_q    <= s_axis_tdata[15:8];
      score_q  <= s_axis_tdata[31:16];
      top_q    <= s_axis_tdata[47:32];
      right_q  <= s_axis_tdata[63:48];
      bottom_q <= s_axis_tdata[79:64];
      left_q   <= s_axis_tdata[95:80];
      ang_q    <= $signed(s_axis_tdata[111:96]);
      rot_q    <= rot_d;
      side_q   <= side_d;
    end
  end

  // angle to q16, one reduction by pi, edge sums and differences, degree product
  always_comb begin
    z_raw = ZW'(ang_q) <<< 3;
    rot_d      = '0;
    rot_d.x    = rtbd_pkg::CORDIC_GAIN_Q16;
    rot_d.z    = z_raw;
    if (z_raw > rtbd_pkg::HALF_PI_Q16) begin
      rot_d.z    = z_raw - rtbd_pkg::PI_Q16;
      rot_d.flip = 1'b1;
    end else if (z_raw < -rtbd_pkg::HALF_PI_Q16) begin
      rot_d.z    = z_raw + rtbd_pkg::PI_Q16;
      rot_d.flip = 1'b1;
    end

    side_d          = '0;
    side_d.col      = col_q;
    side_d.row      = row_q;
    side_d.score    = score_q;
    side_d.dx       = $signed({1'b0, right_q}) - $signed({1'b0, left_q});
    side_d.dy       = $signed({1'b0, bottom_q}) - $signed({1'b0, top_q});
    side_d.width    = DW'(right_q) + DW'(left_q);
    side_d.height   = DW'(top_q) + DW'(bottom_q);
    side_d.deg_prod = (-PW'(ang_q)) * rtbd_pkg::DEG_PER_RAD;
  end

  rtbd_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (valid_set_q),
    .rot_i   (rot_q),
    .side_i  (side_q),
    .valid_o (cor_valid),
    .rot_o   (cor_rot),
    .side_o  (cor_side)
  );

  rtbd_center #(
    .CellStride (CellStride)
  ) u_center (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cor_valid),
    .rot_i   (cor_rot),
    .side_i  (cor_side),
    .valid_o (out_valid),
    .box_o   (box)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, box.confidence, box.angle_deg, box.box_height,
                          box.box_width, box.center_y, box.center_x};

  a_deg_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (box.angle_deg <= 16'sd23040 && box.angle_deg >= -16'sd23040))
    else $error("angle_deg outside saturation range");

  a_conf_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> box.confidence >= thr_q)
    else $error("box emitted for a cell below threshold");

  a_width_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (box.box_width <= 17'd131070 && box.box_height <= 17'd131070))
    else $error("box size beyond sum of two distances");

  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
    else $error("input taken while output is stalled");

endmodule

// ===== tb/rotated_text_box_decoder_test.sv =====
`timescale 1ns / 1ps

module rotated_text_box_decoder_test;

  localparam longint GAIN_Q16     = 39797;
  localparam longint PI_Q16       = 205887;
  localparam longint HALF_PI_Q16  = 102944;
  localparam longint DEG_SCALE    = 58671;
  localparam longint DEG_MAX      = 23040;
  localparam longint CTR_MAX      = 524287;
  localparam longint CTR_MIN      = -524288;
  localparam int     PIPE_LATENCY = 20;
  localparam int     QUIET_LIMIT  = 2000;
  localparam int     RANDOM_CELLS = 240;

  localparam longint ATAN_STEP [16] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2
  };

  localparam int BOUNDARY_ANGLES [8] = '{
    12868, 12869, -12868, -12869, 25736, -25736, -32768, 32767
  };

  // field order matches the slave-side tdata layout, top bits first
  typedef struct packed {
    logic signed [15:0] angle;
    logic        [15:0] left;
    logic        [15:0] bottom;
    logic        [15:0] right;
    logic        [15:0] top;
    logic        [15:0] score;
    logic        [7:0]  row;
    logic        [7:0]  col;
  } cell_t;

  typedef struct packed {
    cell_t               stim;
    logic                typed;
    logic                emits;
    rtbd_pkg::rtbd_box_t box;
  } dir_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [111:0] m_axis_tdata;
  logic         cfg_we_i;
  logic [15:0]  cfg_wdata_i;

  rtbd_pkg::rtbd_box_t pending_boxes [$];
  logic [15:0]  threshold_q;
  int           gap_odds;
  int           mismatch_count;
  int           cells_sent;
  int           boxes_checked;
  int           thresholds_tried;
  int           quiet_cycles;

  // cell: angle, left, bottom, right, top, score, row, col
  // box:  confidence, angle_deg, box_height, box_width, center_y, center_x
  dir_row_t dir_table [20] = '{
    '{'{16'sd0, 16'd100, 16'd200, 16'd300, 16'd400, 16'd16383, 8'd3, 8'd4},
      1'b1, 1'b0, '0},
    '{'{16'sd0, 16'd9, 16'd9, 16'd9, 16'd9, 16'd0, 8'd9, 8'd9},
      1'b1, 1'b0, '0},
    '{'{16'sd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 8'd0, 8'd0},
      1'b1, 1'b1, '{16'd16384, 16'sd0, 17'd0, 17'd0, 20'sd0, 20'sd0}},
    '{'{16'sd0, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd32768, 8'd255, 8'd255},
      1'b1, 1'b1, '{16'd32768, 16'sd0, 17'd131070, 17'd131070, 20'sd16320, 20'sd16320}},
    '{'{-16'sd32768, 16'd0, 16'd0, 16'd0, 16'd0, 16'd65535, 8'd0, 8'd255},
      1'b1, 1'b1, '{16'd65535, 16'sd23040, 17'd0, 17'd0, 20'sd0, 20'sd16320}},
    '{'{16'sd32767, 16'd0, 16'd0, 16'd0, 16'd0, 16'd40000, 8'd255, 8'd0},
      1'b1, 1'b1, '{16'd40000, -16'sd23040, 17'd0, 17'd0, 20'sd16320, 20'sd0}},
    '{'{16'sd12868, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{16'sd12869, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{-16'sd12868, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{-16'sd12869, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{16'sd25736, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{-16'sd25736, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{16'sd6434, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{-16'sd6434, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{16'sd1, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{-16'sd1, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{16'sd8192, 16'd0, 16'd20000, 16'd65535, 16'd10, 16'd20000, 8'd200, 8'd17},
      1'b0, 1'b0, '0},
    '{'{16'sd6434, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd30000, 8'd0, 8'd0},
      1'b0, 1'b0, '0},
    '{'{-16'sd19302, 16'd65535, 16'd0, 16'd0, 16'd65535, 16'd30000, 8'd1, 8'd254},
      1'b0, 1'b0, '0},
    '{'{16'sd3000, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd16385, 8'd128, 8'd127},
      1'b0, 1'b0, '0}
  };

  rotated_text_box_decoder u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic longint clamp_center(input longint v);
    return v < CTR_MIN ? CTR_MIN : (v > CTR_MAX ? CTR_MAX : v);
  endfunction

  // rotated box of one cell, or 0 when the score misses the threshold
  function automatic bit decode_cell(input cell_t c, input logic [15:0] thr,
                                     output rtbd_pkg::rtbd_box_t box);
    longint z, x, y, xs, ys, cs, sn, dx, dy, cx, cy, deg;
    bit     flip;
    box = '0;
    if (c.score < thr) return 1'b0;
    z = longint'(c.angle) * 8;
    x = GAIN_Q16;
    y = 0;
    flip = 1'b0;
    if (z > HALF_PI_Q16) begin
      z = z - PI_Q16;
      flip = 1'b1;
    end else if (z < -HALF_PI_Q16) begin
      z = z + PI_Q16;
      flip = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = y >>> i;
      ys = x >>> i;
      if (z >= 0) begin
        x = x - xs;
        y = y + ys;
        z = z - ATAN_STEP[i];
      end else begin
        x = x + xs;
        y = y - ys;
        z = z + ATAN_STEP[i];
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
    dx = longint'(c.right) - longint'(c.left);
    dy = longint'(c.bottom) - longint'(c.top);
    cx = longint'(c.col) * rtbd_pkg::CELL_STRIDE * 16 * 131072 + cs * dx + sn * dy;
    cy = longint'(c.row) * rtbd_pkg::CELL_STRIDE * 16 * 131072 + cs * dy - sn * dx;
    cx = clamp_center((cx + 65536) >>> 17);
    cy = clamp_center((cy + 65536) >>> 17);
    deg = (-longint'(c.angle) * DEG_SCALE + 32768) >>> 16;
    deg = deg < -DEG_MAX ? -DEG_MAX : (deg > DEG_MAX ? DEG_MAX : deg);
    box.center_x   = cx[19:0];
    box.center_y   = cy[19:0];
    box.box_width  = 17'(longint'(c.right) + longint'(c.left));
    box.box_height = 17'(longint'(c.top) + longint'(c.bottom));
    box.angle_deg  = deg[15:0];
    box.confidence = c.score;
    return 1'b1;
  endfunction

  function automatic logic [15:0] random_dist();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd65535;
      2, 3:    return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic cell_t random_cell(input logic [15:0] thr);
    cell_t c;
    int    s;
    int    pick;
    c.col    = 8'($urandom_range(0, 255));
    c.row    = 8'($urandom_range(0, 255));
    c.top    = random_dist();
    c.right  = random_dist();
    c.bottom = random_dist();
    c.left   = random_dist();
    pick = $urandom_range(0, 9);
    if (pick <= 3) begin
      s = $urandom_range(0, 32768);
    end else if (pick <= 6) begin
      s = int'(thr) + int'($urandom_range(0, 64)) - 32;
      s = s < 0 ? 0 : (s > 65535 ? 65535 : s);
    end else if (pick == 7) begin
      s = $urandom_range(0, 65535);
    end else if (pick == 8) begin
      s = $urandom_range(0, 1) ? 32768 : 0;
    end else begin
      s = int'(thr);
    end
    c.score = 16'(s);
    pick = $urandom_range(0, 19);
    if (pick <= 13) s = int'($urandom_range(0, 51472)) - 25736;
    else if (pick <= 16) s = $urandom_range(0, 65535);
    else s = BOUNDARY_ANGLES[$urandom_range(0, 7)];
    c.angle = 16'(s);
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("box %0d %s got %0d want %0d",
                                boxes_checked, name, got, want));
  endtask

  task automatic send_cell(input cell_t c, input bit typed, input bit typed_emits,
                           input rtbd_pkg::rtbd_box_t typed_box);
    rtbd_pkg::rtbd_box_t box;
    bit        emits;
    if (gap_odds != 0 && $urandom_range(0, gap_odds - 1) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (typed) begin
      emits = typed_emits;
      box   = typed_box;
    end else begin
      emits = decode_cell(c, threshold_q, box);
    end
    if (emits) pending_boxes = {pending_boxes, box};
    cells_sent++;
    @(negedge clk_i);
  endtask

  // drain, let dropped cells clear the pipe, then write the register
  task automatic set_threshold(input logic [15:0] value);
    s_axis_tvalid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    threshold_q = value;
    thresholds_tried++;
  endtask

  task automatic random_phase(input logic [15:0] thr, input int odds);
    gap_odds = odds;
    set_threshold(thr);
    repeat (RANDOM_CELLS) send_cell(random_cell(threshold_q), 1'b0, 1'b0, '0);
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        m_axis_tready = 1'b0;
        stall_left--;
      end else begin
        m_axis_tready = 1'b1;
        if (gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0)
          stall_left = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk_i) begin : box_check
    rtbd_pkg::rtbd_box_t got;
    rtbd_pkg::rtbd_box_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[105:0];
      boxes_checked++;
      if (pending_boxes.size() == 0) begin
        report_mismatch($sformatf("box %0d with no cell pending: %h", boxes_checked, got));
      end else begin
        want = pending_boxes.pop_front();
        check_field("center_x", int'(got.center_x), int'(want.center_x));
        check_field("center_y", int'(got.center_y), int'(want.center_y));
        check_field("box_width", int'(got.box_width), int'(want.box_width));
        check_field("box_height", int'(got.box_height), int'(want.box_height));
        check_field("angle_deg", int'(got.angle_deg), int'(want.angle_deg));
        check_field("confidence", int'(got.confidence), int'(want.confidence));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = '0;
    cells_sent       = 0;
    thresholds_tried = 1;
    threshold_q      = 16'd16384;
    gap_odds         = 4;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_table[i])
      send_cell(dir_table[i].stim, dir_table[i].typed, dir_table[i].emits, dir_table[i].box);

    random_phase(16'd0, 4);
    random_phase(16'd32768, 3);
    random_phase(16'd1, 6);
    random_phase(16'($urandom_range(0, 32768)), 4);
    random_phase(16'($urandom_range(0, 32768)), 2);
    // closing stretch runs at full rate on both sides
    random_phase(16'd16384, 0);

    s_axis_tvalid = 1'b0;
    while (pending_boxes.size() != 0) @(negedge clk_i);
    repeat (PIPE_LATENCY + 10) @(negedge clk_i);
    while (pending_boxes.size() != 0)
      report_mismatch($sformatf("box never came: %h", pending_boxes.pop_front()));

    $display("sent %0d cells (directed extremes, angle wrap, oversize score, random)",
             cells_sent);
    $display("checked %0d boxes over %0d thresholds incl. 0 and 32768, %0d mismatches",
             boxes_checked, thresholds_tried, mismatch_count);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rtbd_pkg.sv
design/rtbd_cordic.sv
design/rtbd_center.sv
design/rotated_text_box_decoder.sv
tb/rotated_text_box_decoder_test.sv
